// ----- sv/real_fft_dft_odft_engine_macros.svh -----
// assertion macros for the real fft engine
`ifndef REAL_FFT_DFT_ODFT_ENGINE_MACROS_SVH
`define REAL_FFT_DFT_ODFT_ENGINE_MACROS_SVH

// same-cycle implication, disabled in reset
`define RFDE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define RFDE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/rfde_pkg.sv -----
// shared constants, types and twiddle rom for the real fft engine
`default_nettype none
package rfde_pkg;

  localparam int REAL_POINTS  = 1024;
  localparam int TWIDDLE_BITS = 16;
  localparam int CPTS   = REAL_POINTS / 2;
  localparam int HALF   = CPTS / 2;
  localparam int LOG_RP = $clog2(REAL_POINTS);
  localparam int LOG_CP = LOG_RP - 1;
  localparam int CW     = LOG_CP;
  localparam int AW     = LOG_RP + 2;
  localparam int RAW    = LOG_RP + 1;
  localparam int STW    = (LOG_CP > 1) ? $clog2(LOG_CP) : 1;
  localparam int XW     = 34;
  localparam int PW     = XW + TWIDDLE_BITS;
  localparam int TRW    = PW + 1 - (TWIDDLE_BITS - 1);
  localparam int EW     = 40;
  localparam longint unsigned CIRCLE = 4 * REAL_POINTS;
  localparam longint signed TW_MAX = (64'sd1 <<< (TWIDDLE_BITS - 1)) - 1;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_RUN   = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [1:0] KIND_ODFT = 2'd1;
  localparam logic [1:0] KIND_MDCT = 2'd2;

  localparam logic [1:0] CFG_DIRECTION = 2'd0;
  localparam logic [1:0] CFG_KIND      = 2'd1;

  localparam logic signed [EW-1:0] S32_MAX = EW'(64'sd2147483647);
  localparam logic signed [EW-1:0] S32_MIN = -S32_MAX - EW'(1);

  typedef struct packed {
    logic [1:0]         req_type;
    logic [9:0]         bin_index;
    logic signed [23:0] re_in;
    logic signed [23:0] im_in;
  } req_t;

  typedef struct packed {
    logic signed [31:0] re_out;
    logic signed [31:0] im_out;
    logic               overflow;
  } res_t;

  typedef struct packed {
    logic        ovf;
    logic [31:0] val;
  } sat_t;

  typedef struct packed {
    logic           neg;
    logic [RAW-1:0] addr;
  } twl_t;

  typedef enum logic [2:0] {
    PH_BREV, PH_DIT, PH_DIF, PH_SPLIT0, PH_SPLIT, PH_SPLITH, PH_SCALE, PH_MDCT
  } phase_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RESP, ST_RDA, ST_RDB, ST_CAP, ST_PREP,
    ST_M0, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5,
    ST_WR1, ST_WR2, ST_NEXT, ST_DONE
  } state_t;

  typedef logic [TWIDDLE_BITS-2:0] tw_rom_t [0:REAL_POINTS];

  function automatic logic [CW-1:0] bit_rev(input logic [CW-1:0] i);
    logic [CW-1:0] r;
    for (int b = 0; b < CW; b++) r[CW-1-b] = i[b];
    return r;
  endfunction

  // fold an angle on the 4N circle onto the quarter-wave table
  function automatic twl_t tw_lookup(input logic [AW-1:0] u);
    twl_t r;
    logic [AW-2:0] h;
    h = u[AW-2:0];
    r.neg = u[AW-1];
    if (h > (AW-1)'(REAL_POINTS)) h = (AW-1)'(0) - h;
    r.addr = h[RAW-1:0];
    return r;
  endfunction

  function automatic sat_t sat32(input logic signed [EW-1:0] v);
    sat_t r;
    r.ovf = 1'b0;
    r.val = v[31:0];
    if (v > S32_MAX) begin
      r.ovf = 1'b1;
      r.val = 32'h7fffffff;
    end else if (v < S32_MIN) begin
      r.ovf = 1'b1;
      r.val = 32'h80000000;
    end
    return r;
  endfunction

  function automatic logic [63:0] tay_step(input logic [63:0] term, input logic [63:0] x2,
                                           input int n);
    logic [63:0] t;
    t = (term * x2 + (64'd1 << 29)) >> 30;
    case (n)
      1: return (t + 64'd3) / 64'd6;
      2: return (t + 64'd10) / 64'd20;
      3: return (t + 64'd21) / 64'd42;
      4: return (t + 64'd36) / 64'd72;
      5: return (t + 64'd55) / 64'd110;
      6: return (t + 64'd78) / 64'd156;
      default: return (t + 64'd105) / 64'd210;
    endcase
  endfunction

  // quarter-wave sine, taylor series in q30 then rounded to the twiddle format
  function automatic tw_rom_t build_tw_rom();
    tw_rom_t rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic signed [63:0] q;
    for (int v = 0; v <= REAL_POINTS; v++) begin
      x = (64'(v) * 64'd6746518852 + CIRCLE / 2) / CIRCLE;
      x2 = (x * x + (64'd1 << 29)) >> 30;
      term = x;
      sum = signed'(x);
      for (int n = 1; n <= 7; n++) begin
        term = tay_step(term, x2, n);
        if ((n & 1) == 1) sum = sum - signed'(term);
        else sum = sum + signed'(term);
      end
      if (sum < 0) sum = 0;
      q = (sum + (64'sd1 <<< (30 - TWIDDLE_BITS))) >>> (31 - TWIDDLE_BITS);
      if (q > TW_MAX) q = TW_MAX;
      rom[v] = (TWIDDLE_BITS-1)'(q);
    end
    return rom;
  endfunction

  localparam tw_rom_t TW_ROM = build_tw_rom();

endpackage
`default_nettype wire

// ----- sv/rfde_ram.sv -----
// generic single-write, single-read ram with registered read
`default_nettype none
module rfde_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- sv/real_fft_dft_odft_engine.sv -----
// real fft engine: frame store, sequencer and shared complex multiplier
//
// usage: pulse start with req while busy is low. a write word stores one bin
// in the cycle it is taken and gives no result. a read word gives one result
// through the registered ram read, the resp state and the result register.
// a run word transforms the frame in place and then gives one result with
// zero data and the saturation flag. results appear on result for one cycle
// with done high; the receiver cannot stall them. direction and transform_kind
// are written on the cfg channel (cfg_ready is always high); the user must
// write them only while the block is idle, and the block does not enforce it.
// a butterfly or split pair steps through read, multiply and write states,
// set by the single multiplier doing four products per twiddle and the one
// read port of the frame rams. reset clears the control state, the
// configuration and the flag; the frame is undefined until written.
`default_nettype none
module real_fft_dft_odft_engine import rfde_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  req_t       req,
  output logic       busy,
  output logic       done,
  output res_t       result,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [1:0] cfg_data
);

  state_t st, st_next;
  phase_t ph;
  logic [CW-1:0]  cnt;
  logic [STW-1:0] stg;
  logic           direction;
  logic [1:0]     transform_kind;
  logic           sat_flag;
  logic           rd_ok;
  res_t           res_next;

  logic odd, mdct;
  logic in_range, take;
  logic [CW-1:0]  a1, a2, kk, lowmask, raddr, waddr;
  logic [AW-1:0]  ang, modd;
  logic [STW:0]   dsh;
  twl_t           twl;
  logic [TWIDDLE_BITS-2:0] rom_q;
  logic           rneg;
  logic signed [TWIDDLE_BITS-1:0] mag, cw, sw;
  logic negs, notw, single, skip_brev, last_cnt, run_end;

  logic [31:0] re_q, im_q;
  logic signed [31:0] ar, ai, br, bi;
  logic signed [XW-1:0] x, y, opa;
  logic signed [TWIDDLE_BITS-1:0] opb;
  logic signed [PW-1:0] prod;
  logic signed [PW:0] acc;
  logic signed [TRW-1:0] tr, ti;
  logic signed [EW-1:0] ear, eai, ebr, ebi, etr, eti;
  logic signed [EW-1:0] rex1f, imx1f, rex1i, imx1i;
  logic signed [EW-1:0] wr_re, wr_im;
  logic wen, ovf;
  sat_t sre, sim;

  assign odd  = (transform_kind == KIND_ODFT);
  assign mdct = (transform_kind == KIND_MDCT);
  assign busy = (st != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_range = ({1'b0, req.bin_index} < 11'(CPTS));
  assign take = start && !busy;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= 1'b0;
      transform_kind <= 2'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DIRECTION: direction <= cfg_data[0];
        CFG_KIND:      transform_kind <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- element addresses and angles ----------------
  always_comb begin
    lowmask = (CW'(1) << stg) - CW'(1);
    kk = cnt & lowmask;
    dsh = (STW+1)'(LOG_RP) - {1'b0, stg};
    modd = AW'({cnt, 1'b1});
    a1 = cnt;
    a2 = cnt;
    ang = '0;
    case (ph)
      PH_BREV: a2 = bit_rev(cnt);
      PH_DIT, PH_DIF: begin
        a1 = ((cnt & ~lowmask) << 1) | kk;
        a2 = a1 | (CW'(1) << stg);
        ang = AW'({kk, odd}) << dsh;
      end
      PH_SPLIT0: begin
        a1 = '0;
        a2 = '0;
      end
      PH_SPLIT: begin
        a2 = odd ? CW'(CPTS - 1) - cnt : CW'(0) - cnt;
        ang = odd ? AW'({cnt, 2'b10}) : AW'({cnt, 2'b00});
      end
      PH_SPLITH: begin
        a1 = CW'(HALF);
        a2 = CW'(HALF);
      end
      PH_MDCT: ang = (modd << LOG_CP) + modd;
      default: ;
    endcase
  end

  assign negs = (ph == PH_DIT) || ((ph == PH_SPLIT || ph == PH_MDCT) && !direction);
  assign notw = (ph == PH_BREV) || (ph == PH_SPLIT0) || (ph == PH_SPLITH) ||
                (ph == PH_SCALE);
  assign single = (ph == PH_SPLIT0) || (ph == PH_SPLITH) || (ph == PH_SCALE) ||
                  (ph == PH_MDCT);
  assign skip_brev = (ph == PH_BREV) && !(cnt < bit_rev(cnt));
  assign last_cnt = (ph == PH_DIT || ph == PH_DIF || ph == PH_SPLIT) ?
                    (cnt == CW'(HALF - 1)) : (cnt == CW'(CPTS - 1));
  assign run_end = ((ph == PH_SPLITH) && !direction) ||
                   ((ph == PH_SPLIT) && last_cnt && odd && !direction) ||
                   ((ph == PH_SCALE || ph == PH_MDCT) && last_cnt);

  // ---------------- twiddle rom ----------------
  // cos is looked up one quarter ahead in the first read cycle, sin in the next
  assign twl = tw_lookup((st == ST_RDA) ? ang + AW'(REAL_POINTS) : ang);
  assign mag = signed'({1'b0, rom_q});

  always_ff @(posedge clk) begin
    rom_q <= TW_ROM[twl.addr];
    rneg  <= twl.neg;
  end

  // ---------------- frame rams ----------------
  always_comb begin
    case (st)
      ST_IDLE: raddr = req.bin_index[CW-1:0];
      ST_RDB:  raddr = a2;
      default: raddr = a1;
    endcase
  end

  rfde_ram #(.WIDTH(32), .DEPTH(CPTS)) u_re_ram (
    .clk(clk), .we(wen), .waddr(waddr), .wdata(sre.val), .raddr(raddr), .rdata(re_q)
  );

  rfde_ram #(.WIDTH(32), .DEPTH(CPTS)) u_im_ram (
    .clk(clk), .we(wen), .waddr(waddr), .wdata(sim.val), .raddr(raddr), .rdata(im_q)
  );

  // ---------------- shared multiplier ----------------
  assign opa = (st == ST_M1 || st == ST_M3) ? y : x;
  assign opb = (st == ST_M0 || st == ST_M3) ? cw : sw;

  always_ff @(posedge clk) begin
    prod <= opa * opb;
    case (st)
      ST_RDB: begin
        ar <= signed'(re_q);
        ai <= signed'(im_q);
        cw <= rneg ? -mag : mag;
      end
      ST_CAP: begin
        br <= signed'(re_q);
        bi <= signed'(im_q);
        sw <= (rneg ^ negs) ? -mag : mag;
      end
      ST_PREP: begin
        case (ph)
          PH_DIF: begin
            x <= XW'(ar) - XW'(br);
            y <= XW'(ai) - XW'(bi);
          end
          PH_SPLIT: begin
            if (direction) begin
              x <= XW'(ar) - XW'(br);
              y <= XW'(ai) + XW'(bi);
            end else begin
              x <= (XW'(ai) + XW'(bi)) >>> 1;
              y <= (XW'(br) - XW'(ar)) >>> 1;
            end
          end
          PH_MDCT: begin
            x <= XW'(ar);
            y <= direction ? '0 : XW'(ai);
          end
          default: begin
            x <= XW'(br);
            y <= XW'(bi);
          end
        endcase
      end
      ST_M1: acc <= (PW+1)'(prod);
      ST_M2: acc <= acc - (PW+1)'(prod);
      ST_M3: begin
        tr  <= TRW'((acc + (PW+1)'(2 ** (TWIDDLE_BITS - 2))) >>> (TWIDDLE_BITS - 1));
        acc <= (PW+1)'(prod);
      end
      ST_M4: acc <= acc + (PW+1)'(prod);
      ST_M5: ti <= TRW'((acc + (PW+1)'(2 ** (TWIDDLE_BITS - 2))) >>> (TWIDDLE_BITS - 1));
      default: ;
    endcase
  end

  // ---------------- write-back ----------------
  assign ear = EW'(ar);
  assign eai = EW'(ai);
  assign ebr = EW'(br);
  assign ebi = EW'(bi);
  assign etr = EW'(tr);
  assign eti = EW'(ti);
  assign rex1f = (ear + ebr) >>> 1;
  assign imx1f = (eai - ebi) >>> 1;
  assign rex1i = ear + ebr;
  assign imx1i = eai - ebi;

  always_comb begin
    wen = 1'b0;
    waddr = a1;
    wr_re = '0;
    wr_im = '0;
    case (st)
      ST_IDLE: begin
        if (take && req.req_type == REQ_WRITE && in_range) wen = 1'b1;
        waddr = req.bin_index[CW-1:0];
        wr_re = EW'(req.re_in);
        wr_im = EW'(req.im_in);
      end
      ST_WR1, ST_WR2: begin
        wen = 1'b1;
        case (ph)
          PH_BREV: begin
            waddr = (st == ST_WR2) ? a1 : a2;
            wr_re = (st == ST_WR2) ? ebr : ear;
            wr_im = (st == ST_WR2) ? ebi : eai;
          end
          PH_DIT: begin
            waddr = (st == ST_WR2) ? a1 : a2;
            wr_re = (st == ST_WR2) ? ear + etr : ear - etr;
            wr_im = (st == ST_WR2) ? eai + eti : eai - eti;
          end
          PH_DIF: begin
            waddr = (st == ST_WR2) ? a2 : a1;
            wr_re = (st == ST_WR2) ? etr : ear + ebr;
            wr_im = (st == ST_WR2) ? eti : eai + ebi;
          end
          PH_SPLIT0: begin
            wr_re = ear + eai;
            wr_im = ear - eai;
          end
          PH_SPLIT: begin
            waddr = (st == ST_WR2) ? a2 : a1;
            if (direction) begin
              wr_re = (st == ST_WR2) ? rex1i + eti : rex1i - eti;
              wr_im = (st == ST_WR2) ? etr - imx1i : imx1i + etr;
            end else begin
              wr_re = (st == ST_WR2) ? rex1f - etr : rex1f + etr;
              wr_im = (st == ST_WR2) ? eti - imx1f : imx1f + eti;
            end
          end
          PH_SPLITH: begin
            wr_re = direction ? ear <<< 1 : ear;
            wr_im = direction ? -(eai <<< 1) : -eai;
          end
          PH_SCALE: begin
            // divide by n with round half up
            wr_re = (ear + EW'(2 ** (LOG_RP - 1))) >>> LOG_RP;
            wr_im = (eai + EW'(2 ** (LOG_RP - 1))) >>> LOG_RP;
          end
          default: begin
            wr_re = etr;
            wr_im = eti;
          end
        endcase
      end
      default: ;
    endcase
  end

  assign sre = sat32(wr_re);
  assign sim = sat32(wr_im);
  assign ovf = wen && (sre.ovf || sim.ovf);

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) st <= ST_IDLE;
    else st <= st_next;
  end

  always_comb begin
    st_next = st;
    res_next = '0;
    res_next.overflow = sat_flag;
    case (st)
      ST_IDLE: begin
        if (take && req.req_type == REQ_RUN) st_next = ST_RDA;
        else if (take && req.req_type == REQ_READ) st_next = ST_RESP;
      end
      ST_RESP: begin
        st_next = ST_IDLE;
        if (rd_ok) begin
          res_next.re_out = signed'(re_q);
          res_next.im_out = signed'(im_q);
        end
      end
      ST_RDA:  st_next = skip_brev ? ST_NEXT : ST_RDB;
      ST_RDB:  st_next = ST_CAP;
      ST_CAP:  st_next = notw ? ST_WR1 : ST_PREP;
      ST_PREP: st_next = ST_M0;
      ST_M0:   st_next = ST_M1;
      ST_M1:   st_next = ST_M2;
      ST_M2:   st_next = ST_M3;
      ST_M3:   st_next = ST_M4;
      ST_M4:   st_next = ST_M5;
      ST_M5:   st_next = ST_WR1;
      ST_WR1:  st_next = single ? ST_NEXT : ST_WR2;
      ST_WR2:  st_next = ST_NEXT;
      ST_NEXT: st_next = run_end ? ST_DONE : ST_RDA;
      ST_DONE: st_next = ST_IDLE;
      default: st_next = ST_IDLE;
    endcase
  end

  // phase, stage and element counters, saturation flag, read flag and done
  always_ff @(posedge clk) begin
    if (rst) begin
      ph <= PH_BREV;
      cnt <= '0;
      stg <= '0;
      sat_flag <= 1'b0;
      rd_ok <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= (st == ST_RESP) || (st == ST_DONE);
      if (take && req.req_type == REQ_READ) rd_ok <= in_range;
      if (take && req.req_type == REQ_RUN) begin
        sat_flag <= 1'b0;
        cnt <= '0;
        stg <= '0;
        if (mdct) ph <= PH_MDCT;
        else if (!direction) ph <= PH_BREV;
        else ph <= odd ? PH_SPLIT : PH_SPLIT0;
      end else if (ovf && st != ST_IDLE) begin
        sat_flag <= 1'b1;
      end
      if (st == ST_NEXT) begin
        case (ph)
          PH_BREV: begin
            if (last_cnt) begin
              cnt <= '0;
              stg <= '0;
              ph <= direction ? PH_SCALE : PH_DIT;
            end else cnt <= cnt + 1'b1;
          end
          PH_DIT: begin
            if (last_cnt) begin
              cnt <= '0;
              if (stg == STW'(LOG_CP - 1)) ph <= odd ? PH_SPLIT : PH_SPLIT0;
              else stg <= stg + 1'b1;
            end else cnt <= cnt + 1'b1;
          end
          PH_DIF: begin
            if (last_cnt) begin
              cnt <= '0;
              if (stg == '0) ph <= PH_BREV;
              else stg <= stg - 1'b1;
            end else cnt <= cnt + 1'b1;
          end
          PH_SPLIT0: begin
            ph <= PH_SPLIT;
            cnt <= CW'(1);
          end
          PH_SPLIT: begin
            if (last_cnt) begin
              if (!odd) ph <= PH_SPLITH;
              else if (direction) begin
                ph <= PH_DIF;
                stg <= STW'(LOG_CP - 1);
                cnt <= '0;
              end
            end else cnt <= cnt + 1'b1;
          end
          PH_SPLITH: begin
            if (direction) begin
              ph <= PH_DIF;
              stg <= STW'(LOG_CP - 1);
              cnt <= '0;
            end
          end
          default: cnt <= cnt + 1'b1;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    result <= res_next;
  end

  // ---------------- assertions ----------------
`include "real_fft_dft_odft_engine_macros.svh"

  `RFDE_ASSERT_NEXT(a_write_stays_idle, take && req.req_type == REQ_WRITE, !busy, "write word made the block busy")
  `RFDE_ASSERT_NEXT(a_run_read_busy, take && (req.req_type == REQ_RUN || req.req_type == REQ_READ), busy, "run or read word did not start")
  `RFDE_ASSERT_NEXT(a_run_result, st == ST_DONE, done && result.re_out == 0 && result.im_out == 0, "run result missing or not zero")
  `RFDE_ASSERT_SAME(a_no_write_in_read, st == ST_RDB || st == ST_CAP || st == ST_RESP, !wen, "frame written during a read cycle")

endmodule
`default_nettype wire
